[design/assert_macros.svh]
// Shared assertion macros for the block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/acbc_pkg.sv]
package acbc_pkg;

	localparam int RoundCount = 10;
	localparam int KeyDepth = RoundCount + 1;
	localparam int KeyAddrBits = $clog2(KeyDepth);
	localparam int BlockBits = 128;
	localparam int BlockBytes = 16;
	localparam int HalfBits = 64;
	localparam int CfgAddrBits = 5;

	typedef struct packed {
		logic [HalfBits-1:0] cipher_high;
		logic [HalfBits-1:0] cipher_low;
		logic                final_block;
	} blk_t;

	typedef struct packed {
		logic [HalfBits-1:0] plain_high;
		logic [HalfBits-1:0] plain_low;
		logic                end_of_message;
		logic [7:0]          pad_length;
	} res_t;

	typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_LOAD, ST_ROUND} state_t;
	typedef enum logic [1:0] {REG_KEY_HIGH, REG_KEY_LOW, REG_IV_HIGH, REG_IV_LOW} reg_idx_t;
	typedef enum logic [1:0] {RM_ADD, RM_MID, RM_LAST} rmode_t;

	typedef logic [7:0] byte_tbl_t [256];

	// Elaboration-time field arithmetic used to build the S-box tables.
	function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] p;
		a = a_in;
		b = b_in;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) p = p ^ a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = {1'b0, b[7:1]};
		end
		return p;
	endfunction

	// Inverse as x^254, zero maps to zero.
	function automatic logic [7:0] gf_inv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] b;
		r = 8'h01;
		b = x;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gf_mul(r, b);
			b = gf_mul(b, b);
		end
		return (x == 8'h00) ? 8'h00 : r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		logic [15:0] d;
		d = {v, v} << n;
		return d[15:8];
	endfunction

	function automatic byte_tbl_t gen_sbox();
		byte_tbl_t t;
		logic [7:0] v;
		for (int k = 0; k < 256; k++) begin
			v = gf_inv(8'(k));
			t[k] = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
		end
		return t;
	endfunction

	function automatic byte_tbl_t gen_inv_sbox();
		byte_tbl_t t;
		logic [7:0] y;
		for (int k = 0; k < 256; k++) begin
			y = 8'(k);
			t[k] = gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
		end
		return t;
	endfunction

	localparam byte_tbl_t SBOX = gen_sbox();
	localparam byte_tbl_t INV_SBOX = gen_inv_sbox();

	// Round constant for the key word produced in expansion step i.
	function automatic logic [7:0] rcon_of(input logic [KeyAddrBits-1:0] i);
		logic [7:0] r;
		case (i)
			4'd1: r = 8'h01;
			4'd2: r = 8'h02;
			4'd3: r = 8'h04;
			4'd4: r = 8'h08;
			4'd5: r = 8'h10;
			4'd6: r = 8'h20;
			4'd7: r = 8'h40;
			4'd8: r = 8'h80;
			4'd9: r = 8'h1b;
			4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[design/aes128_cbc_decryptor.sv]
// Channel  Direction  Handshake            Payload
// blk      in         blk_valid/blk_ready  blk (acbc_pkg::blk_t)
// res      out        res_valid/res_ready  res (acbc_pkg::res_t)
// cfg      in         APB psel/penable     paddr, pwdata, prdata
// A block is accepted in the idle state, then passes a key RAM load state and the round
// states, one per round key read from the key RAM, from the initial key add to the final round.
// The first block of a message first expands the key schedule into that RAM.
// Reset clears the configuration and control registers and the message flag, not the datapath;
// the key RAM is rewritten at every message start. A full result register stalls the last round.
module aes128_cbc_decryptor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [acbc_pkg::CfgAddrBits-1:0]    paddr,
	input  logic [acbc_pkg::HalfBits-1:0]       pwdata,
	output logic [acbc_pkg::HalfBits-1:0]       prdata,
	output logic                                pready,
	input  logic                                blk_valid,
	output logic                                blk_ready,
	input  acbc_pkg::blk_t                      blk,
	output logic                                res_valid,
	input  logic                                res_ready,
	output acbc_pkg::res_t                      res
);
	import acbc_pkg::*;

	logic [HalfBits-1:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	state_t state_q, state_d;
	logic [KeyAddrBits-1:0] cnt_q;
	logic [BlockBits-1:0] st_q, cblk_q, chain_q, rk_q;
	logic final_q, in_msg_q, out_valid_q;
	res_t out_q;

	logic accept, out_free, finish, ram_we, ram_re;
	logic [KeyAddrBits-1:0] ram_raddr;
	logic [BlockBits-1:0] ram_rdata, st_next, key_next, plain;
	rmode_t mode;
	reg_idx_t cfg_idx;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[CfgAddrBits-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			iv_high_q <= '0;
			iv_low_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (cfg_idx)
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_KEY_LOW:  key_low_q <= pwdata;
				REG_IV_HIGH:  iv_high_q <= pwdata;
				REG_IV_LOW:   iv_low_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_KEY_HIGH: prdata = key_high_q;
			REG_KEY_LOW:  prdata = key_low_q;
			REG_IV_HIGH:  prdata = iv_high_q;
			REG_IV_LOW:   prdata = iv_low_q;
			default:      prdata = '0;
		endcase
	end

	// Round key RAM, one 128-bit round key per entry.
	acbc_ram #(.Width(BlockBits), .Depth(KeyDepth)) u_key_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(cnt_q),
		.wdata(rk_q),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	acbc_round u_round (
		.mode(mode),
		.st(st_q),
		.rk(ram_rdata),
		.st_next(st_next),
		.key_cur(rk_q),
		.rcon(rcon_of(cnt_q + 1'b1)),
		.key_next(key_next)
	);

	assign blk_ready = (state_q == ST_IDLE);
	assign accept = blk_valid && blk_ready;
	assign out_free = !out_valid_q || res_ready;
	assign plain = st_next ^ chain_q;

	// Sequencer: next state, RAM strobes and round mode.
	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_raddr = cnt_q - 1'b1;
		finish = 1'b0;
		mode = RM_MID;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = in_msg_q ? ST_LOAD : ST_EXPAND;
			end
			ST_EXPAND: begin
				ram_we = 1'b1;
				if (cnt_q == KeyAddrBits'(RoundCount)) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				ram_re = 1'b1;
				ram_raddr = KeyAddrBits'(RoundCount);
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (cnt_q == KeyAddrBits'(RoundCount)) begin
					mode = RM_ADD;
					ram_re = 1'b1;
				end else if (cnt_q != '0) begin
					ram_re = 1'b1;
				end else begin
					mode = RM_LAST;
					if (out_free) begin
						finish = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Counter, message flag and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			in_msg_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= '0;
				in_msg_q <= 1'b1;
			end else if (state_q == ST_EXPAND) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_LOAD) begin
				cnt_q <= KeyAddrBits'(RoundCount);
			end else if (state_q == ST_ROUND && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (finish && final_q) in_msg_q <= 1'b0;
			if (finish) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			st_q <= {blk.cipher_high, blk.cipher_low};
			cblk_q <= {blk.cipher_high, blk.cipher_low};
			final_q <= blk.final_block;
			rk_q <= {key_high_q, key_low_q};
			if (!in_msg_q) chain_q <= {iv_high_q, iv_low_q};
		end else if (state_q == ST_EXPAND) begin
			rk_q <= key_next;
		end else if (state_q == ST_ROUND && cnt_q != '0) begin
			st_q <= st_next;
		end
		if (finish) begin
			chain_q <= cblk_q;
			out_q.plain_high <= plain[127:64];
			out_q.plain_low <= plain[63:0];
			out_q.end_of_message <= final_q;
			out_q.pad_length <= final_q ? plain[7:0] : 8'h00;
		end
	end

	assign res_valid = out_valid_q;
	assign res = out_q;

endmodule

[design/acbc_ram.sv]
module acbc_ram #(
	parameter int Width = 128,
	parameter int Depth = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// One write port, one registered read port; read data holds when idle.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

[design/acbc_round.sv]
module acbc_round (
	input  acbc_pkg::rmode_t                    mode,
	input  logic [acbc_pkg::BlockBits-1:0]      st,
	input  logic [acbc_pkg::BlockBits-1:0]      rk,
	output logic [acbc_pkg::BlockBits-1:0]      st_next,
	input  logic [acbc_pkg::BlockBits-1:0]      key_cur,
	input  logic [7:0]                          rcon,
	output logic [acbc_pkg::BlockBits-1:0]      key_next
);
	import acbc_pkg::*;

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	logic [BlockBits-1:0] isb;
	logic [BlockBits-1:0] added;
	logic [BlockBits-1:0] mixed;
	logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;

	// Inverse ShiftRows folded into the inverse S-box lookup.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				isb[BlockBits-1-8*(r+4*c) -: 8] =
					INV_SBOX[st[BlockBits-1-8*(r+4*((c-r+4)%4)) -: 8]];
			end
		end
	end

	assign added = isb ^ rk;

	// Inverse MixColumns, one column of four bytes at a time.
	always_comb begin
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = added[BlockBits-1-8*(4*c+k) -: 8];
				x2[k] = xtime(a[k]);
				x4[k] = xtime(x2[k]);
				x8[k] = xtime(x4[k]);
				m9[k] = x8[k] ^ a[k];
				m11[k] = x8[k] ^ x2[k] ^ a[k];
				m13[k] = x8[k] ^ x4[k] ^ a[k];
				m14[k] = x8[k] ^ x4[k] ^ x2[k];
			end
			mixed[BlockBits-1-8*(4*c) -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
			mixed[BlockBits-1-8*(4*c+1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
			mixed[BlockBits-1-8*(4*c+2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
			mixed[BlockBits-1-8*(4*c+3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
		end
	end

	// Round selection: initial key add, middle round, or final round.
	always_comb begin
		case (mode)
			RM_ADD:  st_next = st ^ rk;
			RM_MID:  st_next = mixed;
			RM_LAST: st_next = added;
			default: st_next = st ^ rk;
		endcase
	end

	// One step of the forward key schedule.
	assign w0 = key_cur[127:96];
	assign w1 = key_cur[95:64];
	assign w2 = key_cur[63:32];
	assign w3 = key_cur[31:0];
	assign t = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
		^ {rcon, 24'h000000};
	assign n0 = w0 ^ t;
	assign n1 = w1 ^ n0;
	assign n2 = w2 ^ n1;
	assign n3 = w3 ^ n2;
	assign key_next = {n0, n1, n2, n3};

endmodule

[design/acbc_checker.sv]
module acbc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             pready,
	input logic                             blk_valid,
	input logic                             blk_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input acbc_pkg::res_t                   res
);
	import acbc_pkg::*;
	`include "assert_macros.svh"

	// The configuration port never inserts wait states.
	`ASSERT_SAME(a_pready_high, clk, arst_n, 1'b1, pready, "pready dropped")
	// A stalled result stays offered.
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped")
	// An accepted item keeps the block busy in the next cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, blk_valid && blk_ready, !blk_ready,
		"input taken twice in a row")
	// Pad length is zero except on a message's last block.
	`ASSERT_SAME(a_pad_zero, clk, arst_n, res_valid && !res.end_of_message,
		res.pad_length == 8'h00, "pad length on non-final block")

endmodule

bind aes128_cbc_decryptor acbc_checker u_acbc_checker (.*);
